// ===== rtl/lfp_pkg.sv =====
package lfp_pkg;

  localparam int SENSOR_MAX       = 8;
  localparam int SENSOR_COUNT_DEF = 8;
  localparam int SENSOR_W         = 16;
  localparam int ERR_W            = 3;
  localparam int DELTA_W          = ERR_W + 1;
  localparam int INTEG_W          = 16;
  localparam int GAIN_W           = 16;
  localparam int DRIVE_W          = 8;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 16;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd5;

  localparam logic [SENSOR_W-1:0]       THRESHOLD_RST = 16'd1000;
  localparam logic signed [DRIVE_W-1:0] BASE_RST      = 8'sd40;
  localparam logic signed [DRIVE_W-1:0] TRIM_RST      = 8'sd0;
  localparam logic [GAIN_W-1:0]         GAIN_P_RST    = 16'd768;
  localparam logic [GAIN_W-1:0]         GAIN_D_RST    = 16'd256;
  localparam logic [GAIN_W-1:0]         GAIN_I_RST    = 16'd26;

  typedef struct packed {
    logic [SENSOR_W-1:0] sensor_0;
    logic [SENSOR_W-1:0] sensor_1;
    logic [SENSOR_W-1:0] sensor_2;
    logic [SENSOR_W-1:0] sensor_3;
    logic [SENSOR_W-1:0] sensor_4;
    logic [SENSOR_W-1:0] sensor_5;
    logic [SENSOR_W-1:0] sensor_6;
    logic [SENSOR_W-1:0] sensor_7;
  } frame_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]   line_error;
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_beat_t;

  typedef struct packed {
    logic [SENSOR_W-1:0]       detect_threshold;
    logic signed [DRIVE_W-1:0] base_speed;
    logic signed [DRIVE_W-1:0] right_trim;
    logic [GAIN_W-1:0]         gain_p;
    logic [GAIN_W-1:0]         gain_d;
    logic [GAIN_W-1:0]         gain_i;
  } cfg_regs_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]   line_error;
    logic signed [DELTA_W-1:0] err_delta;
    logic signed [INTEG_W-1:0] integral;
  } err_beat_t;

endpackage

// ===== rtl/lfp_chan_if.sv =====
interface lfp_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/line_follow_pid.sv =====
// PID steering for a reflectance sensor line follower.
// frame (sink): one beat carries a frame of eight 16-bit sensor readings;
//   only the first SENSOR_COUNT readings take part.
// result (source): one beat per frame with the line error and the left and
//   right motor drives, in frame order.
// cfg (sink): register writes by index, always ready; write only while no
//   frame is in flight.
// Pipeline: an accepted frame passes these registered stages in order before
//   its result shows on result.valid: sensor compare lanes, error merge and
//   integral update, gain products, correction and drive saturation.
// Throughput: one frame per cycle while result.ready is high; every stage is a
//   register with its own valid, and the integral is updated in the merge stage.
// Reset clears every stage valid, the stored error and the error sum, and
//   loads the register defaults.
// When result.ready is low the result holds; upstream stages keep taking
//   frames until all four stages are full, then frame.ready drops.
module line_follow_pid import lfp_pkg::*; #(
  parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lfp_chan_if.sink   frame,
  lfp_chan_if.source result,
  lfp_chan_if.sink   cfg
);

  cfg_regs_t                 regs;
  logic [SENSOR_W-1:0]       readings [SENSOR_MAX];
  logic [SENSOR_COUNT-1:0]   hits;
  logic                      lane_valid;
  logic                      lane_ready;
  logic                      lane_load;
  logic                      merge_ready;
  logic                      err_valid;
  logic                      pid_ready;
  err_beat_t                 err_beat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.detect_threshold <= THRESHOLD_RST;
      regs.base_speed       <= BASE_RST;
      regs.right_trim       <= TRIM_RST;
      regs.gain_p           <= GAIN_P_RST;
      regs.gain_d           <= GAIN_D_RST;
      regs.gain_i           <= GAIN_I_RST;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_THRESHOLD: regs.detect_threshold <= cfg.data.value;
        REG_BASE:      regs.base_speed       <= cfg.data.value[DRIVE_W-1:0];
        REG_TRIM:      regs.right_trim       <= cfg.data.value[DRIVE_W-1:0];
        REG_GAIN_P:    regs.gain_p           <= cfg.data.value;
        REG_GAIN_D:    regs.gain_d           <= cfg.data.value;
        REG_GAIN_I:    regs.gain_i           <= cfg.data.value;
        default: ;
      endcase
    end
  end

  assign readings[0] = frame.data.sensor_0;
  assign readings[1] = frame.data.sensor_1;
  assign readings[2] = frame.data.sensor_2;
  assign readings[3] = frame.data.sensor_3;
  assign readings[4] = frame.data.sensor_4;
  assign readings[5] = frame.data.sensor_5;
  assign readings[6] = frame.data.sensor_6;
  assign readings[7] = frame.data.sensor_7;

  assign lane_ready  = !lane_valid || merge_ready;
  assign frame.ready = lane_ready;
  assign lane_load   = frame.valid && lane_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid <= 1'b0;
    end else if (lane_ready) begin
      lane_valid <= frame.valid;
    end
  end

  for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
    lfp_lane u_lane (
      .clk       (clk),
      .load      (lane_load),
      .reading   (readings[g]),
      .threshold (regs.detect_threshold),
      .hit       (hits[g])
    );
  end

  lfp_merge #(
    .SENSOR_COUNT (SENSOR_COUNT)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lane_valid),
    .in_ready  (merge_ready),
    .hits      (hits),
    .out_valid (err_valid),
    .out_ready (pid_ready),
    .out_beat  (err_beat)
  );

  lfp_pid u_pid (
    .clk      (clk),
    .rst      (rst),
    .in_valid (err_valid),
    .in_ready (pid_ready),
    .in_beat  (err_beat),
    .regs     (regs),
    .result   (result)
  );

endmodule

// ===== rtl/lfp_lane.sv =====
module lfp_lane import lfp_pkg::*; (
  input  logic                clk,
  input  logic                load,
  input  logic [SENSOR_W-1:0] reading,
  input  logic [SENSOR_W-1:0] threshold,
  output logic                hit
);

  always_ff @(posedge clk) begin
    if (load) begin
      hit <= reading > threshold;
    end
  end

endmodule

// ===== rtl/lfp_merge.sv =====
module lfp_merge import lfp_pkg::*; #(
  parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SENSOR_COUNT-1:0] hits,
  output logic                    out_valid,
  input  logic                    out_ready,
  output err_beat_t               out_beat
);

  localparam int HALF = SENSOR_COUNT / 2;
  localparam logic signed [INTEG_W:0] INTEG_MAX = (INTEG_W+1)'((1 << (INTEG_W - 1)) - 1);
  localparam logic signed [INTEG_W:0] INTEG_MIN = (INTEG_W+1)'(-(1 << (INTEG_W - 1)));

  logic signed [ERR_W-1:0]   previous_error;
  logic signed [INTEG_W-1:0] error_integral;
  logic signed [ERR_W-1:0]   left_err;
  logic                      left_found;
  logic [ERR_W-1:0]          right_mag;
  logic                      right_found;
  logic signed [ERR_W-1:0]   err;
  logic signed [INTEG_W:0]   sum_wide;
  logic signed [INTEG_W-1:0] sum_sat;
  logic signed [DELTA_W-1:0] delta;
  logic                      load;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    left_err   = '0;
    left_found = 1'b0;
    for (int i = HALF - 1; i >= 0; i--) begin
      if (hits[i]) begin
        left_err   = ERR_W'(HALF - 1 - i);
        left_found = 1'b1;
      end
    end
    right_mag   = '0;
    right_found = 1'b0;
    for (int j = HALF; j < SENSOR_COUNT; j++) begin
      if (hits[j]) begin
        right_mag   = ERR_W'(j - HALF);
        right_found = 1'b1;
      end
    end
    err = left_found ? left_err : '0;
    if (right_found && ($signed({err[ERR_W-1], err}) < $signed({1'b0, right_mag}))) begin
      err = ERR_W'(DELTA_W'(0) - {1'b0, right_mag});
    end
  end

  always_comb begin
    sum_wide = (INTEG_W+1)'(error_integral) + (INTEG_W+1)'(err);
    if (sum_wide > INTEG_MAX) begin
      sum_sat = INTEG_MAX[INTEG_W-1:0];
    end else if (sum_wide < INTEG_MIN) begin
      sum_sat = INTEG_MIN[INTEG_W-1:0];
    end else begin
      sum_sat = sum_wide[INTEG_W-1:0];
    end
    delta = DELTA_W'(err) - DELTA_W'(previous_error);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      previous_error <= '0;
      error_integral <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (load) begin
        previous_error <= err;
        error_integral <= sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_beat.line_error <= err;
      out_beat.err_delta  <= delta;
      out_beat.integral   <= sum_sat;
    end
  end

endmodule

// ===== rtl/lfp_pid.sv =====
module lfp_pid import lfp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  err_beat_t         in_beat,
  input  cfg_regs_t         regs,
  lfp_chan_if.source        result
);

  localparam int P_W    = GAIN_W + ERR_W + 1;
  localparam int D_W    = GAIN_W + DELTA_W + 1;
  localparam int I_W    = GAIN_W + INTEG_W + 1;
  localparam int CORR_W = I_W + 2;
  localparam int ACC_W  = CORR_W + 1;
  localparam int Q_W    = ACC_W - 8;

  typedef struct packed {
    logic signed [ERR_W-1:0] line_error;
    logic signed [P_W-1:0]   p_term;
    logic signed [D_W-1:0]   d_term;
    logic signed [I_W-1:0]   i_term;
  } prod_beat_t;

  function automatic logic signed [DRIVE_W-1:0] trunc_sat(input logic signed [ACC_W-1:0] x);
    logic signed [Q_W-1:0] q;
    q = x[ACC_W-1:8];
    if (x[ACC_W-1] && (x[7:0] != '0)) begin
      q = q + Q_W'(1);
    end
    if (q > Q_W'(127)) begin
      return DRIVE_W'(127);
    end else if (q < Q_W'(-128)) begin
      return DRIVE_W'(-128);
    end
    return q[DRIVE_W-1:0];
  endfunction

  prod_beat_t                prod;
  logic                      prod_valid;
  logic                      prod_ready;
  logic                      out_ready;
  logic signed [GAIN_W:0]    gp;
  logic signed [GAIN_W:0]    gd;
  logic signed [GAIN_W:0]    gi;
  logic signed [CORR_W-1:0]  corr;
  logic signed [ACC_W-1:0]   left_acc;
  logic signed [ACC_W-1:0]   right_acc;

  assign out_ready  = !result.valid || result.ready;
  assign prod_ready = !prod_valid || out_ready;
  assign in_ready   = prod_ready;

  assign gp = {1'b0, regs.gain_p};
  assign gd = {1'b0, regs.gain_d};
  assign gi = {1'b0, regs.gain_i};

  always_ff @(posedge clk) begin
    if (in_valid && prod_ready) begin
      prod.line_error <= in_beat.line_error;
      prod.p_term     <= P_W'(gp) * P_W'(in_beat.line_error);
      prod.d_term     <= D_W'(gd) * D_W'(in_beat.err_delta);
      prod.i_term     <= I_W'(gi) * I_W'(in_beat.integral);
    end
  end

  always_comb begin
    corr      = CORR_W'(prod.p_term) + CORR_W'(prod.d_term) + CORR_W'(prod.i_term);
    left_acc  = (ACC_W'(regs.base_speed) <<< 8) - ACC_W'(corr);
    right_acc = ((ACC_W'(regs.base_speed) + ACC_W'(regs.right_trim)) <<< 8) + ACC_W'(corr);
  end

  always_ff @(posedge clk) begin
    if (prod_valid && out_ready) begin
      result.data.line_error  <= prod.line_error;
      result.data.left_drive  <= trunc_sat(left_acc);
      result.data.right_drive <= trunc_sat(right_acc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid   <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid <= in_valid;
      end
      if (out_ready) begin
        result.valid <= prod_valid;
      end
    end
  end

endmodule
